// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

    // Second header byte length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Output tdata width: fin, opcode, masked, frame_len, out_byte, padded to bytes
    localparam int OUT_TDATA_W = 80;

    // Result kinds carried on tuser
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // One received beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] frame_len;
        logic [7:0]  out_byte;
        logic        last;
    } result_t;

endpackage

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer.
//
//  Channel   Dir  tdata                                         tuser        tlast
//  s_axis    in   [7:0] in_byte                                 frame_start  -
//  m_axis    out  [0] fin [4:1] opcode [5] masked               kind         last
//                 [69:6] frame_len [77:70] out_byte
//
// One beat per cycle while the sink does not stall: a received byte is registered
// in the input register, then parsed and unmasked by the header state machine, and
// the result lands in the output register, so throughput is one byte per cycle.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to waiting for a first header byte. A stalled sink holds the output register
// and backs up through the input register; header bytes that give no result
// still advance while the output register is free.
`timescale 1ns / 1ps

module websocket_frame_deframer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] in_byte
    input  logic                              s_axis_tuser,   // [0] frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wsfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // fin, opcode, masked,
                                                              // frame_len, out_byte
    output logic                              m_axis_tuser,   // [0] kind
    output logic                              m_axis_tlast    // last
);
    import wsfd_pkg::*;

    in_item_t item;
    result_t  res;
    logic     item_valid;
    logic     res_valid;
    logic     out_free;
    logic     step;

    // Parser advances when a beat is held and the output register has room
    assign step = item_valid && out_free;

    wsfd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (step),
        .item_valid    (item_valid),
        .item          (item)
    );

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && res_valid),
        .res           (res),
        .can_take      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/wsfd_in_stage.sv =====
// Input register stage: captures one received beat and holds it for the parser.
`timescale 1ns / 1ps

module wsfd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] in_byte
    input  logic                s_axis_tuser,   // [0] frame_start
    input  logic                take,           // parser consumes the held beat
    output logic                item_valid,
    output wsfd_pkg::in_item_t  item
);
    import wsfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Room when empty or when the held beat leaves this cycle
    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.in_byte     <= s_axis_tdata;
            item_reg.frame_start <= s_axis_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/wsfd_parser.sv =====
// Header parse state machine and payload unmasking, one beat per cycle while step is high.
`timescale 1ns / 1ps

module wsfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,           // process the beat on item this cycle
    input  wsfd_pkg::in_item_t  item,
    output logic                res_valid,
    output wsfd_pkg::result_t   res
);
    import wsfd_pkg::*;

    // Parse phases
    localparam logic [2:0] PH_B0   = 3'd0;
    localparam logic [2:0] PH_B1   = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [2:0]  phase_reg,     phase_next;
    logic        fin_reg,       fin_next;
    logic [3:0]  opcode_reg,    opcode_next;
    logic        mask_reg,      mask_next;
    logic [63:0] length_reg,    length_next;
    logic [2:0]  hidx_reg,      hidx_next;
    logic [31:0] key_reg,       key_next;
    logic [1:0]  kphase_reg,    kphase_next;
    logic [63:0] remain_reg,    remain_next;

    logic [2:0]  phase;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic        hdr_done;
    logic        after_len;
    logic        pay_out;
    logic        pay_last;

    assign len7 = item.in_byte[6:0];

    // Key byte for the current payload position, most significant first
    always_comb
    begin
        unique case (kphase_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        hidx_next   = hidx_reg;
        key_next    = key_reg;
        kphase_next = kphase_reg;
        remain_next = remain_reg;
        after_len   = 1'b0;
        hdr_done    = 1'b0;
        pay_out     = 1'b0;
        pay_last    = 1'b0;

        // Resync or unused phase code restarts at the first header byte
        phase = (item.frame_start || phase_reg > PH_DATA) ? PH_B0 : phase_reg;

        unique case (phase)
            PH_B0:
            begin
                fin_next    = item.in_byte[7];
                opcode_next = item.in_byte[3:0];
                phase_next  = PH_B1;
            end
            PH_B1:
            begin
                mask_next   = item.in_byte[7];
                key_next    = 32'd0;
                length_next = 64'd0;
                if (len7 == LEN_EXT16)
                begin
                    hidx_next  = 3'd1;
                    phase_next = PH_EXT;
                end
                else if (len7 == LEN_EXT64)
                begin
                    hidx_next  = 3'd7;
                    phase_next = PH_EXT;
                end
                else
                begin
                    length_next = {57'd0, len7};
                    after_len   = 1'b1;
                end
            end
            PH_EXT:
            begin
                length_next = {length_reg[55:0], item.in_byte};
                if (hidx_reg == 3'd0)
                begin
                    after_len = 1'b1;
                end
                else
                begin
                    hidx_next = hidx_reg - 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], item.in_byte};
                if (hidx_reg == 3'd0)
                begin
                    hdr_done = 1'b1;
                end
                else
                begin
                    hidx_next = hidx_reg - 3'd1;
                end
            end
            PH_DATA:
            begin
                pay_out     = 1'b1;
                kphase_next = kphase_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                pay_last    = (remain_reg == 64'd1);
                if (remain_reg == 64'd1)
                begin
                    phase_next = PH_B0;
                end
            end
            default:
            begin
                phase_next = PH_B1;
            end
        endcase

        // Length complete: fetch the key, or the header is done
        if (after_len)
        begin
            if (mask_next)
            begin
                phase_next = PH_KEY;
                hidx_next  = 3'd3;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            remain_next = length_next;
            kphase_next = 2'd0;
            phase_next  = (length_next == 64'd0) ? PH_B0 : PH_DATA;
        end
    end

    // Result for this beat
    always_comb
    begin
        res_valid          = hdr_done || pay_out;
        res.kind           = pay_out ? KIND_PAYLOAD : KIND_HEADER;
        res.fin            = fin_next;
        res.opcode         = opcode_next;
        res.masked         = mask_next;
        res.frame_len      = length_next;
        res.out_byte       = pay_out ? (item.in_byte ^ key_byte) : 8'd0;
        res.last           = pay_out ? pay_last : (length_next == 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_B0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            length_reg <= 64'd0;
            hidx_reg   <= 3'd0;
            key_reg    <= 32'd0;
            kphase_reg <= 2'd0;
            remain_reg <= 64'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            length_reg <= length_next;
            hidx_reg   <= hidx_next;
            key_reg    <= key_next;
            kphase_reg <= kphase_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== rtl/wsfd_out_stage.sv =====
// Output register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module wsfd_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,       // new result this cycle
    input  wsfd_pkg::result_t             res,
    output logic                          can_take,   // register free next edge
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wsfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import wsfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // Pack fields, lowest bit first
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {2'b00, res_reg.out_byte, res_reg.frame_len,
                            res_reg.masked, res_reg.opcode, res_reg.fin};

endmodule
